/* hdl/tdc_pkg.sv */
// ----------------------------------------------------------------------------
// tdc_pkg
// Constants and status codes shared by the template delimiter checker.
// ----------------------------------------------------------------------------
package tdc_pkg;

    // Width of the internal line counter; it saturates at its all-ones value.
    localparam int LINE_BITS = 16;

    localparam int BYTE_BITS   = 8;
    localparam int STATUS_BITS = 3;
    localparam int LINE_OUT_BITS = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 24;

    typedef logic [BYTE_BITS-1:0]     byte_t;
    typedef logic [STATUS_BITS-1:0]   status_t;
    typedef logic [LINE_BITS-1:0]     line_t;
    typedef logic [LINE_OUT_BITS-1:0] line_out_t;

    // Result status codes.
    localparam status_t ST_OK           = 3'd0;
    localparam status_t ST_STRAY_CLOSE  = 3'd1;
    localparam status_t ST_OPEN_STMT    = 3'd2;
    localparam status_t ST_OPEN_RAW     = 3'd3;
    localparam status_t ST_OPEN_COMMENT = 3'd4;
    localparam status_t ST_STAR_CLOSE   = 3'd5;
    localparam status_t ST_LT_CLOSE     = 3'd6;
    localparam status_t ST_NESTED_OPEN  = 3'd7;

    // Delimiter characters.
    localparam byte_t CH_NONE   = 8'h00;
    localparam byte_t CH_NL     = 8'h0A;
    localparam byte_t CH_LPAREN = 8'h28;
    localparam byte_t CH_RPAREN = 8'h29;
    localparam byte_t CH_STAR   = 8'h2A;
    localparam byte_t CH_LT     = 8'h3C;
    localparam byte_t CH_GT     = 8'h3E;

    localparam line_t LINE_ONE = line_t'(1);
    localparam line_t LINE_MAX = '1;

endpackage

/* hdl/template_delimiter_checker.sv */
// ----------------------------------------------------------------------------
// template_delimiter_checker
// Byte-stream checker for template statement delimiters.
// ----------------------------------------------------------------------------
// Usage:
// Template text enters on the s_ channel, one byte per request, with s_tlast
// on the final byte of a buffer. A result leaves on the m_ channel: a status
// code and a line number. The first error of a buffer is reported on the
// byte that completes it; a clean buffer reports OK with its line count on
// the last byte. After an error the rest of the buffer is dropped quietly.
// Results are registered. Throughput is one byte per cycle unless a pending
// result is stalled: the scanner state and the result register both update
// in the accept cycle, set by a single pass of the per-byte state update.
// When the receiver stalls, the result register holds and s_tready stays
// high only if the pending result is taken in that same cycle.
// Reset puts the scanner in text mode with line one and no pending result;
// the scanner also returns to that state after every last byte.
// ----------------------------------------------------------------------------
module template_delimiter_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tdc_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [7:0] text_byte
    input  logic                               s_tlast,   // end_of_text
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tdc_pkg::OUT_DATA_BITS-1:0]  m_tdata    // [2:0] check_status,
                                                          // [18:3] line_number
);
    import tdc_pkg::*;

    typedef enum logic [2:0]
    {
        MODE_TEXT,
        MODE_OPENED,
        MODE_STMT,
        MODE_RAW,
        MODE_COMMENT,
        MODE_DISCARD
    } mode_t;

    mode_t     mode_reg, mode_next;
    byte_t     prev_reg, prev_next;
    byte_t     prev2_reg, prev2_next;
    logic      nested_reg, nested_next;
    line_t     line_reg, line_next;
    logic      out_valid_reg;
    status_t   out_status_reg, res_status;
    line_out_t out_line_reg, res_line;
    logic      res_valid;
    logic      accept;
    byte_t     b;
    status_t   err;
    line_t     line_inc;

    function automatic line_out_t clamp_line(line_t v);
        logic [32:0] ext;
        ext = 33'(v);
        clamp_line = (ext > 33'h0FFFF) ? '1 : ext[LINE_OUT_BITS-1:0];
    endfunction

    assign b        = s_tdata[BYTE_BITS-1:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        mode_next   = mode_reg;
        prev_next   = prev_reg;
        prev2_next  = prev2_reg;
        nested_next = nested_reg;
        err         = ST_OK;

        case (mode_reg)
            MODE_OPENED:
            begin
                if (b == CH_GT)
                begin
                    mode_next  = MODE_RAW;
                    prev_next  = CH_NONE;
                    prev2_next = CH_NONE;
                end
                else if (b == CH_STAR)
                begin
                    // The opening star may also begin the comment terminator.
                    mode_next  = MODE_COMMENT;
                    prev_next  = CH_STAR;
                    prev2_next = CH_NONE;
                end
                else
                begin
                    mode_next   = MODE_STMT;
                    nested_next = 1'b0;
                    prev_next   = b;
                    prev2_next  = CH_NONE;
                end
            end
            MODE_STMT:
            begin
                if (prev_reg == CH_RPAREN && b == CH_GT)
                begin
                    if (prev2_reg == CH_STAR)
                        err = ST_STAR_CLOSE;
                    else if (prev2_reg == CH_LT)
                        err = ST_LT_CLOSE;
                    else if (nested_reg)
                        err = ST_NESTED_OPEN;
                    else
                    begin
                        mode_next  = MODE_TEXT;
                        prev_next  = CH_NONE;
                        prev2_next = CH_NONE;
                    end
                end
                else
                begin
                    if (prev_reg == CH_LT && b == CH_LPAREN)
                        nested_next = 1'b1;
                    prev2_next = prev_reg;
                    prev_next  = b;
                end
            end
            MODE_RAW:
            begin
                if (prev2_reg == CH_LT && prev_reg == CH_RPAREN && b == CH_GT)
                begin
                    mode_next  = MODE_TEXT;
                    prev_next  = CH_NONE;
                    prev2_next = CH_NONE;
                end
                else
                begin
                    prev2_next = prev_reg;
                    prev_next  = b;
                end
            end
            MODE_COMMENT:
            begin
                if (prev2_reg == CH_STAR && prev_reg == CH_RPAREN && b == CH_GT)
                begin
                    mode_next  = MODE_TEXT;
                    prev_next  = CH_NONE;
                    prev2_next = CH_NONE;
                end
                else
                begin
                    prev2_next = prev_reg;
                    prev_next  = b;
                end
            end
            MODE_DISCARD:
            begin
            end
            default:
            begin
                if (prev_reg == CH_RPAREN && b == CH_GT)
                    err = ST_STRAY_CLOSE;
                else if (prev_reg == CH_LT && b == CH_LPAREN)
                begin
                    mode_next  = MODE_OPENED;
                    prev_next  = CH_NONE;
                    prev2_next = CH_NONE;
                end
                else
                begin
                    prev2_next = prev_reg;
                    prev_next  = b;
                end
            end
        endcase

        line_inc = line_reg;
        if (b == CH_NL && line_reg != LINE_MAX)
            line_inc = line_reg + LINE_ONE;
        line_next = line_inc;

        res_valid  = 1'b0;
        res_status = ST_OK;
        res_line   = clamp_line(line_inc);
        if (err != ST_OK)
        begin
            // Errors report the line of the byte that completed them.
            res_valid  = 1'b1;
            res_status = err;
            res_line   = clamp_line(line_reg);
            mode_next  = MODE_DISCARD;
        end
        else if (s_tlast && mode_reg != MODE_DISCARD)
        begin
            res_valid = 1'b1;
            case (mode_next)
                MODE_OPENED, MODE_STMT: res_status = ST_OPEN_STMT;
                MODE_RAW:               res_status = ST_OPEN_RAW;
                MODE_COMMENT:           res_status = ST_OPEN_COMMENT;
                default:                res_status = ST_OK;
            endcase
        end

        if (s_tlast)
        begin
            mode_next   = MODE_TEXT;
            prev_next   = CH_NONE;
            prev2_next  = CH_NONE;
            nested_next = 1'b0;
            line_next   = LINE_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TEXT;
            prev_reg      <= CH_NONE;
            prev2_reg     <= CH_NONE;
            nested_reg    <= 1'b0;
            line_reg      <= LINE_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                prev_reg   <= prev_next;
                prev2_reg  <= prev2_next;
                nested_reg <= nested_next;
                line_reg   <= line_next;
            end
            if (s_tready)
                out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_status_reg <= res_status;
            out_line_reg   <= res_line;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS - STATUS_BITS - LINE_OUT_BITS){1'b0}},
                       out_line_reg, out_status_reg};

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the template delimiter checker. A queue of
// text bytes feeds a stream driver, a scanner model predicts the status
// and line of each buffer, and a monitor compares every result it takes.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tdc_pkg::*;

    localparam int IDLE_PCT    = 18;
    localparam int HOLD_START  = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_START  = 1200;
    localparam int CALM_END    = 1900;
    localparam int RANDOM_BYTES = 1950;
    localparam int DRAIN_CYCLES = 10;
    localparam longint unsigned LINE_OUT_MAX = (64'd1 << LINE_OUT_BITS) - 1;

    typedef enum logic [2:0]
    {
        SCAN_TEXT,
        SCAN_OPENED,
        SCAN_STMT,
        SCAN_RAW,
        SCAN_COMMENT,
        SCAN_DISCARD
    } scan_mode_e;

    typedef struct packed
    {
        byte_t data;
        logic  last;
    } text_req_t;

    typedef struct packed
    {
        status_t   status;
        line_out_t line;
    } report_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    text_req_t pending_text[$];
    report_t   expected_reports[$];
    int        error_count = 0;

    // Scanner model state.
    scan_mode_e scan_mode = SCAN_TEXT;
    byte_t      prev_byte = CH_NONE;
    byte_t      prev2_byte = CH_NONE;
    logic       nested_seen = 1'b0;
    line_t      cur_line = LINE_ONE;

    template_delimiter_checker DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic line_out_t clamp_line(input line_t value);
        longint unsigned wide;
        wide = 64'(value);
        return (wide > LINE_OUT_MAX) ? line_out_t'(LINE_OUT_MAX) : line_out_t'(wide);
    endfunction

    function automatic void reset_scanner();
        scan_mode   = SCAN_TEXT;
        prev_byte   = CH_NONE;
        prev2_byte  = CH_NONE;
        nested_seen = 1'b0;
        cur_line    = LINE_ONE;
    endfunction

    // Advances the scanner model by one byte and queues the report it causes.
    function automatic void scan_byte(input byte_t b, input logic last);
        logic    has_err;
        status_t err_code;
        status_t end_code;
        line_t   err_line;
        logic    was_discard;
        report_t rep;
        has_err     = 1'b0;
        err_code    = ST_OK;
        err_line    = cur_line;
        was_discard = (scan_mode == SCAN_DISCARD);
        case (scan_mode)
            SCAN_OPENED:
            begin
                if (b == CH_GT)
                begin
                    scan_mode  = SCAN_RAW;
                    prev_byte  = CH_NONE;
                    prev2_byte = CH_NONE;
                end
                else if (b == CH_STAR)
                begin
                    // This star may also begin the comment terminator.
                    scan_mode  = SCAN_COMMENT;
                    prev2_byte = CH_NONE;
                    prev_byte  = CH_STAR;
                end
                else
                begin
                    scan_mode   = SCAN_STMT;
                    nested_seen = 1'b0;
                    prev2_byte  = CH_NONE;
                    prev_byte   = b;
                end
            end
            SCAN_STMT:
            begin
                if (prev_byte == CH_RPAREN && b == CH_GT)
                begin
                    has_err = 1'b1;
                    if (prev2_byte == CH_STAR)
                        err_code = ST_STAR_CLOSE;
                    else if (prev2_byte == CH_LT)
                        err_code = ST_LT_CLOSE;
                    else if (nested_seen)
                        err_code = ST_NESTED_OPEN;
                    else
                    begin
                        has_err    = 1'b0;
                        scan_mode  = SCAN_TEXT;
                        prev_byte  = CH_NONE;
                        prev2_byte = CH_NONE;
                    end
                end
                else
                begin
                    if (prev_byte == CH_LT && b == CH_LPAREN)
                        nested_seen = 1'b1;
                    prev2_byte = prev_byte;
                    prev_byte  = b;
                end
            end
            SCAN_RAW:
            begin
                if (prev2_byte == CH_LT && prev_byte == CH_RPAREN && b == CH_GT)
                begin
                    scan_mode  = SCAN_TEXT;
                    prev_byte  = CH_NONE;
                    prev2_byte = CH_NONE;
                end
                else
                begin
                    prev2_byte = prev_byte;
                    prev_byte  = b;
                end
            end
            SCAN_COMMENT:
            begin
                if (prev2_byte == CH_STAR && prev_byte == CH_RPAREN && b == CH_GT)
                begin
                    scan_mode  = SCAN_TEXT;
                    prev_byte  = CH_NONE;
                    prev2_byte = CH_NONE;
                end
                else
                begin
                    prev2_byte = prev_byte;
                    prev_byte  = b;
                end
            end
            SCAN_DISCARD:
            begin
            end
            default:
            begin
                if (prev_byte == CH_RPAREN && b == CH_GT)
                begin
                    has_err  = 1'b1;
                    err_code = ST_STRAY_CLOSE;
                end
                else if (prev_byte == CH_LT && b == CH_LPAREN)
                begin
                    scan_mode  = SCAN_OPENED;
                    prev_byte  = CH_NONE;
                    prev2_byte = CH_NONE;
                end
                else
                begin
                    prev2_byte = prev_byte;
                    prev_byte  = b;
                end
            end
        endcase

        if (b == CH_NL && cur_line != LINE_MAX)
            cur_line = cur_line + 1'b1;

        if (has_err)
        begin
            rep.status = err_code;
            rep.line   = clamp_line(err_line);
            expected_reports = {expected_reports, rep};
            scan_mode = SCAN_DISCARD;
        end
        else if (last && !was_discard)
        begin
            case (scan_mode)
                SCAN_OPENED, SCAN_STMT: end_code = ST_OPEN_STMT;
                SCAN_RAW:               end_code = ST_OPEN_RAW;
                SCAN_COMMENT:           end_code = ST_OPEN_COMMENT;
                default:                end_code = ST_OK;
            endcase
            rep.status = end_code;
            rep.line   = clamp_line(cur_line);
            expected_reports = {expected_reports, rep};
        end

        if (last)
            reset_scanner();
    endfunction

    function automatic void push_byte(input byte_t b, input logic last);
        text_req_t req;
        req.data = b;
        req.last = last;
        pending_text = {pending_text, req};
    endfunction

    function automatic void push_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            push_byte(byte_t'(s[i]), last && (i == s.len() - 1));
    endfunction

    // Random byte; delim_pct sets how often a delimiter character comes up.
    function automatic byte_t pick_byte(input int delim_pct);
        int r;
        r = $urandom_range(99);
        if (r >= delim_pct)
            return byte_t'($urandom_range(255));
        case ($urandom_range(6))
            0:       return CH_LT;
            1:       return CH_RPAREN;
            2:       return CH_GT;
            3:       return CH_LPAREN;
            4:       return CH_STAR;
            5:       return CH_NL;
            default: return CH_NONE;
        endcase
    endfunction

    // Builds one buffer from well-formed constructs with random content,
    // cut short now and then, with tlast on its final byte.
    function automatic int push_random_buffer();
        byte_t buf_bytes[$];
        int    segs;
        int    len;
        byte_t first;
        segs = $urandom_range(1, 5);
        for (int s = 0; s < segs; s++)
        begin
            len = $urandom_range(0, 6);
            case ($urandom_range(9))
                0, 1:
                begin
                    for (int i = 0; i < len; i++)
                        buf_bytes = {buf_bytes, pick_byte(10)};
                end
                2, 3, 4:
                begin
                    buf_bytes = {buf_bytes, CH_LT, CH_LPAREN};
                    do
                        first = pick_byte(15);
                    while (first == CH_GT || first == CH_STAR);
                    buf_bytes = {buf_bytes, first};
                    for (int i = 0; i < len; i++)
                        buf_bytes = {buf_bytes, pick_byte(12)};
                    buf_bytes = {buf_bytes, CH_RPAREN, CH_GT};
                end
                5, 6:
                begin
                    buf_bytes = {buf_bytes, CH_LT, CH_LPAREN, CH_GT};
                    for (int i = 0; i < len; i++)
                        buf_bytes = {buf_bytes, pick_byte(25)};
                    buf_bytes = {buf_bytes, CH_LT, CH_RPAREN, CH_GT};
                end
                7, 8:
                begin
                    buf_bytes = {buf_bytes, CH_LT, CH_LPAREN, CH_STAR};
                    for (int i = 0; i < len; i++)
                        buf_bytes = {buf_bytes, pick_byte(25)};
                    buf_bytes = {buf_bytes, CH_STAR, CH_RPAREN, CH_GT};
                end
                default:
                begin
                    for (int i = 0; i <= len; i++)
                        buf_bytes = {buf_bytes, pick_byte(70)};
                end
            endcase
        end
        if (buf_bytes.size() > 1 && $urandom_range(99) < 15)
            buf_bytes = buf_bytes[0:$urandom_range(buf_bytes.size() - 2)];
        if (buf_bytes.size() == 0)
            buf_bytes = {buf_bytes, pick_byte(50)};
        foreach (buf_bytes[i])
            push_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        return buf_bytes.size();
    endfunction

    // Stream driver: a new request is offered only once the current one
    // has been taken, so tvalid is never dropped while a request waits.
    int drv_cycle = 0;
    always @(posedge clk or negedge rst_n)
    begin
        text_req_t next_req;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tlast   <= 1'b0;
            drv_cycle <= 0;
        end
        else
        begin
            drv_cycle <= drv_cycle + 1;
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (pending_text.size() != 0 &&
                    ((drv_cycle >= CALM_START && drv_cycle < CALM_END) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    next_req = pending_text.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.data;
                    s_tlast  <= next_req.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off that backs up the block,
    // and a window with no stalls at all.
    int rcv_cycle = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rcv_cycle <= 0;
        end
        else
        begin
            rcv_cycle <= rcv_cycle + 1;
            if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else if (rcv_cycle >= CALM_START && rcv_cycle < CALM_END)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        report_t want;
        status_t got_status;
        line_out_t got_line;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_status = m_tdata[STATUS_BITS-1:0];
            got_line   = m_tdata[STATUS_BITS +: LINE_OUT_BITS];
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d line %0d",
                         $time, got_status, got_line);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got_status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got_status);
                    error_count++;
                end
                if (got_line !== want.line)
                begin
                    $display("%0t: line mismatch: expected %0d, actual %0d",
                             $time, want.line, got_line);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int random_total;
        random_total = 0;

        // Directed buffers: each error kind, each unclosed kind, errors on
        // the last byte, a discarded tail, and the byte values zero and 255.
        push_text(")>", 1'b1);
        push_text("<(", 1'b1);
        push_text("<(>", 1'b1);
        push_text("<(*", 1'b1);
        push_text("<(a*)>", 1'b0);
        push_text("\n", 1'b1);
        push_text("<(<)>", 1'b1);
        push_text("<(<()>", 1'b1);
        push_text("<(><)><(*)><(x)>", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("\n", 1'b1);

        while (random_total < RANDOM_BYTES)
            random_total += push_random_buffer();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_text.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
